// ----- rtl/rrfw_pkg.sv -----
// Package with shared widths, register indexes and reset values for the rotated frame writer.
package rrfw_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    localparam int COLOR_W  = 8;
    localparam int PACKED_W = 16;
    localparam int OFFSET_W = 23;
    localparam int SRC_W    = 20;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 11;
    localparam int PITCH_W  = 14;
    localparam int CFG_DATA_W  = 14;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_DRAW_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_COUNT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTER_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_X_PITCH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_PITCH     = 3'd4;

    localparam logic [MODE_W-1:0] MODE_PORTRAIT_FLIPPED = 2'd0;

    localparam int INNER_COUNT_RESET = 240;
    localparam int OUTER_COUNT_RESET = 320;
    localparam int X_PITCH_RESET     = 2;
    localparam int Y_PITCH_RESET     = 480;

endpackage

// ----- rtl/rotated_rgb565_frame_writer.sv -----
// Top level of the rotated RGB565 frame writer: counters, offset math and output register.
//
// Each input item is one 24-bit source pixel (red, green, blue) in the order the
// rotating copy consumes it. Each item yields exactly one result item carrying the
// RGB565 word, the framebuffer offset in 16-bit words, the source pixel index and a
// frame end flag on the last pixel of a frame. Both channels use valid and ready.
// An item passes an input register and then an output register before its result
// appears. One item is accepted per cycle as long as the receiver takes results; the
// rate is set by the two registered stages, which each hold one item. When the receiver
// stalls, the output register holds its result and the input register fills behind it,
// after which in_ready drops. Reset loads the register defaults (mode 0, 240 by 320
// pixels, pitches 2 and 480) and puts the loop counters at the start of a frame. Any
// configuration write to a valid index restarts the frame for the new settings. The user
// must write configuration via cfg_write_en, cfg_index and cfg_data only while no item
// is in flight; the block itself does not enforce it.
module rotated_rgb565_frame_writer #(
    parameter int MAX_DIM = rrfw_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write_en,
    input  logic [rrfw_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [rrfw_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [rrfw_pkg::COLOR_W-1:0]            red,
    input  logic [rrfw_pkg::COLOR_W-1:0]            green,
    input  logic [rrfw_pkg::COLOR_W-1:0]            blue,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [rrfw_pkg::OFFSET_W-1:0]    dest_offset,
    output logic [rrfw_pkg::PACKED_W-1:0]           packed_color,
    output logic [rrfw_pkg::SRC_W-1:0]              source_pixel,
    output logic                                    frame_end
);
    import rrfw_pkg::*;

    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int PROD_W = POS_W + 1 + PITCH_W;
    localparam int SUM_W  = (PROD_W + 1 > OFFSET_W) ? PROD_W + 1 : OFFSET_W;
    localparam int TOT_W  = 2 * CNT_W;
    localparam int RESET_OC = (OUTER_COUNT_RESET > MAX_DIM) ? MAX_DIM : OUTER_COUNT_RESET;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
        logic [CMP_W-1:0] w;
        w = CMP_W'(c);
        if (w == '0)
            return CNT_W'(1);
        else if (w > CMP_W'(MAX_DIM))
            return CNT_W'(MAX_DIM);
        else
            return CNT_W'(w);
    endfunction

    // Configuration registers.
    logic [MODE_W-1:0]         draw_mode_reg, draw_mode_next;
    logic [COUNT_W-1:0]        inner_count_reg, inner_count_next;
    logic [COUNT_W-1:0]        outer_count_reg, outer_count_next;
    logic signed [PITCH_W-1:0] x_pitch_reg, x_pitch_next;
    logic signed [PITCH_W-1:0] y_pitch_reg, y_pitch_next;

    // Loop counters.
    logic [POS_W-1:0] outer_pos_reg, outer_pos_next;
    logic [POS_W-1:0] inner_pos_reg, inner_pos_next;
    logic [SRC_W-1:0] pixels_done_reg, pixels_done_next;

    // Input stage.
    logic                s1_valid_reg;
    logic [POS_W-1:0]    s1_x_reg, s1_y_reg;
    logic [SRC_W-1:0]    s1_pd_reg;
    logic                s1_forward_reg;
    logic                s1_last_reg;
    logic [PACKED_W-1:0] s1_color_reg;

    // Output stage.
    logic                       out_valid_reg;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic [PACKED_W-1:0]        color_reg;
    logic [SRC_W-1:0]           src_reg, src_next;
    logic                       last_reg;

    logic [CNT_W-1:0] ic, oc, ic_new, oc_new;
    logic             landscape;
    logic             last_now;
    logic             cfg_hit;
    logic             in_accept, s1_advance, out_advance;
    logic [CNT_W-1:0] inner_inc;
    logic [TOT_W-1:0] total;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [SUM_W-1:0]  offset_sum;

    assign ic        = clamp_count(inner_count_reg);
    assign oc        = clamp_count(outer_count_reg);
    assign landscape = (draw_mode_reg != MODE_PORTRAIT_FLIPPED);

    assign out_advance = !out_valid_reg || out_ready;
    assign s1_advance  = !s1_valid_reg || out_advance;
    assign in_ready    = s1_advance;
    assign in_accept   = in_valid && in_ready;

    always_comb
    begin
        draw_mode_next   = draw_mode_reg;
        inner_count_next = inner_count_reg;
        outer_count_next = outer_count_reg;
        x_pitch_next     = x_pitch_reg;
        y_pitch_next     = y_pitch_reg;
        cfg_hit          = 1'b0;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_DRAW_MODE:
                begin
                    draw_mode_next = cfg_data[MODE_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_INNER_COUNT:
                begin
                    inner_count_next = cfg_data[COUNT_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_OUTER_COUNT:
                begin
                    outer_count_next = cfg_data[COUNT_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_X_PITCH:
                begin
                    x_pitch_next = $signed(cfg_data[PITCH_W-1:0]);
                    cfg_hit = 1'b1;
                end
                REG_Y_PITCH:
                begin
                    y_pitch_next = $signed(cfg_data[PITCH_W-1:0]);
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    assign ic_new    = clamp_count(inner_count_next);
    assign oc_new    = clamp_count(outer_count_next);
    assign inner_inc = CNT_W'(inner_pos_reg) + CNT_W'(1);

    always_comb
    begin
        outer_pos_next   = outer_pos_reg;
        inner_pos_next   = inner_pos_reg;
        pixels_done_next = pixels_done_reg;
        last_now         = 1'b0;
        if (landscape)
        begin
            if (inner_pos_reg == '0)
            begin
                inner_pos_next = POS_W'(ic - CNT_W'(1));
                if (outer_pos_reg == '0)
                begin
                    last_now       = 1'b1;
                    outer_pos_next = POS_W'(oc - CNT_W'(1));
                end
                else
                begin
                    outer_pos_next = outer_pos_reg - POS_W'(1);
                end
            end
            else
            begin
                inner_pos_next = inner_pos_reg - POS_W'(1);
            end
        end
        else
        begin
            inner_pos_next = POS_W'(inner_inc);
            if (inner_inc >= ic)
            begin
                inner_pos_next = '0;
                if (outer_pos_reg == '0)
                begin
                    last_now       = 1'b1;
                    outer_pos_next = POS_W'(oc - CNT_W'(1));
                end
                else
                begin
                    outer_pos_next = outer_pos_reg - POS_W'(1);
                end
            end
        end
        pixels_done_next = last_now ? '0 : pixels_done_reg + SRC_W'(1);

        if (cfg_hit)
        begin
            outer_pos_next   = POS_W'(oc_new - CNT_W'(1));
            inner_pos_next   = (draw_mode_next == MODE_PORTRAIT_FLIPPED) ?
                               '0 : POS_W'(ic_new - CNT_W'(1));
            pixels_done_next = '0;
        end
        else if (!in_accept)
        begin
            outer_pos_next   = outer_pos_reg;
            inner_pos_next   = inner_pos_reg;
            pixels_done_next = pixels_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_mode_reg   <= MODE_PORTRAIT_FLIPPED;
            inner_count_reg <= COUNT_W'(INNER_COUNT_RESET);
            outer_count_reg <= COUNT_W'(OUTER_COUNT_RESET);
            x_pitch_reg     <= PITCH_W'(X_PITCH_RESET);
            y_pitch_reg     <= PITCH_W'(Y_PITCH_RESET);
            outer_pos_reg   <= POS_W'(RESET_OC - 1);
            inner_pos_reg   <= '0;
            pixels_done_reg <= '0;
        end
        else
        begin
            draw_mode_reg   <= draw_mode_next;
            inner_count_reg <= inner_count_next;
            outer_count_reg <= outer_count_next;
            x_pitch_reg     <= x_pitch_next;
            y_pitch_reg     <= y_pitch_next;
            outer_pos_reg   <= outer_pos_next;
            inner_pos_reg   <= inner_pos_next;
            pixels_done_reg <= pixels_done_next;
        end
    end

    // Input stage captures the coordinates, the pixel count, the order bit, the frame end flag and the packed color.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg       <= landscape ? outer_pos_reg : inner_pos_reg;
            s1_y_reg       <= landscape ? inner_pos_reg : outer_pos_reg;
            s1_pd_reg      <= pixels_done_reg;
            s1_forward_reg <= draw_mode_reg[MODE_W-1];
            s1_last_reg    <= last_now;
            s1_color_reg   <= {red[7:3], green[7:2], blue[7:3]};
        end
    end

    // Offset is floor(x*xpitch/2) + floor(y*ypitch/2), wrapped to the output width.
    assign prod_x     = $signed({1'b0, s1_x_reg}) * x_pitch_reg;
    assign prod_y     = $signed({1'b0, s1_y_reg}) * y_pitch_reg;
    assign offset_sum = SUM_W'(prod_x >>> 1) + SUM_W'(prod_y >>> 1);
    assign offset_next = offset_sum[OFFSET_W-1:0];

    assign total    = ic * oc;
    assign src_next = s1_forward_reg ? s1_pd_reg :
                      SRC_W'(total) - SRC_W'(1) - s1_pd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
        begin
            offset_reg <= offset_next;
            color_reg  <= s1_color_reg;
            src_reg    <= src_next;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_offset  = offset_reg;
    assign packed_color = color_reg;
    assign source_pixel = src_reg;
    assign frame_end    = last_reg;

    // The loop counters always stay inside the current frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(inner_pos_reg) < ic) && (CNT_W'(outer_pos_reg) < oc))
        else $error("Loop counter outside the frame.");

    // The input side only stalls while the input stage holds an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("Input stalled without a full pipeline.");

    // The pixel count restarts after the last pixel of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && last_now) |=> (pixels_done_reg == '0))
        else $error("Pixel count did not restart at frame end.");

endmodule

// ----- sim/tb_rotated_rgb565_frame_writer.sv -----
// Self-checking testbench for the rotated RGB565 frame writer with a built-in pixel walk predictor.
`timescale 1ns / 1ps

module tb_rotated_rgb565_frame_writer;
    import rrfw_pkg::*;

    localparam int DIM_LIMIT = MAX_DIM_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_AFTER = 650;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LANDSCAPE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
    localparam logic [PITCH_W-1:0] PITCH_MOST_NEGATIVE = 14'h2000;
    localparam logic [PITCH_W-1:0] PITCH_MOST_POSITIVE = 14'h1FFF;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] dest_offset;
        logic [PACKED_W-1:0] packed_color;
        logic [SRC_W-1:0]    source_pixel;
        logic                frame_end;
    } blit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [COLOR_W-1:0] red = '0;
    logic [COLOR_W-1:0] green = '0;
    logic [COLOR_W-1:0] blue = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OFFSET_W-1:0] dest_offset;
    logic [PACKED_W-1:0] packed_color;
    logic [SRC_W-1:0] source_pixel;
    logic frame_end;

    pixel_t pixel_q[$];
    blit_result_t blit_q[$];
    blit_result_t want;
    int mismatches = 0;
    int cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    int in_idle_odds = 0;
    int out_idle_odds = 0;

    logic [MODE_W-1:0] mode_q;
    logic [COUNT_W-1:0] inner_q;
    logic [COUNT_W-1:0] outer_q;
    logic signed [PITCH_W-1:0] xpitch_q;
    logic signed [PITCH_W-1:0] ypitch_q;
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned sent_count;

    rotated_rgb565_frame_writer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_offset  (dest_offset),
        .packed_color (packed_color),
        .source_pixel (source_pixel),
        .frame_end    (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(logic [COUNT_W-1:0] c);
        if (c == 0)
        begin
            return 1;
        end
        if (c > DIM_LIMIT)
        begin
            return DIM_LIMIT;
        end
        return c;
    endfunction

    function automatic void restart_walk();
        row_pos = clamp_dim(outer_q) - 1;
        col_pos = (mode_q == MODE_PORTRAIT_FLIPPED) ? 0 : clamp_dim(inner_q) - 1;
        sent_count = 0;
    endfunction

    function automatic blit_result_t blit_pixel(pixel_t px);
        blit_result_t r;
        int unsigned ic;
        int unsigned oc;
        int unsigned x;
        int unsigned y;
        int unsigned src;
        logic landscape;
        logic wrap;
        longint sum;
        ic = clamp_dim(inner_q);
        oc = clamp_dim(outer_q);
        landscape = (mode_q != MODE_PORTRAIT_FLIPPED);
        x = landscape ? row_pos : col_pos;
        y = landscape ? col_pos : row_pos;
        sum = ((longint'(x) * longint'(xpitch_q)) >>> 1)
            + ((longint'(y) * longint'(ypitch_q)) >>> 1);
        src = mode_q[1] ? sent_count : ic * oc - 1 - sent_count;
        r.dest_offset = sum[OFFSET_W-1:0];
        r.packed_color = {px.red[7:3], px.green[7:2], px.blue[7:3]};
        r.source_pixel = src[SRC_W-1:0];
        wrap = 1'b0;
        if (landscape)
        begin
            if (col_pos == 0)
            begin
                col_pos = ic - 1;
                wrap = (row_pos == 0);
                row_pos = wrap ? oc - 1 : row_pos - 1;
            end
            else
            begin
                col_pos = col_pos - 1;
            end
        end
        else
        begin
            col_pos = col_pos + 1;
            if (col_pos >= ic)
            begin
                col_pos = 0;
                wrap = (row_pos == 0);
                row_pos = wrap ? oc - 1 : row_pos - 1;
            end
        end
        sent_count = wrap ? 0 : sent_count + 1;
        r.frame_end = wrap;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DRAW_MODE:   mode_q = val[MODE_W-1:0];
            REG_INNER_COUNT: inner_q = val[COUNT_W-1:0];
            REG_OUTER_COUNT: outer_q = val[COUNT_W-1:0];
            REG_X_PITCH:     xpitch_q = val;
            REG_Y_PITCH:     ypitch_q = val;
            default:         return;
        endcase
        restart_walk();
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || blit_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        pixel_q.push_back(px);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        logic [2:0] junk;
        junk = 3'($urandom());
        case ($urandom_range(0, 11))
            0: return 14'd0;
            1: return {junk, 11'd0};
            2: return 14'd1;
            3: return 14'd1024;
            4: return 14'($urandom_range(1025, 2047));
            default: return {junk, 11'($urandom_range(2, 6))};
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pitch();
        case ($urandom_range(0, 7))
            0: return PITCH_MOST_NEGATIVE;
            1: return PITCH_MOST_POSITIVE;
            2: return 14'd0;
            3: return 14'($urandom_range(0, 8)) - 14'd4;
            default: return 14'($urandom());
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL rotated_rgb565_frame_writer");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                blit_q.push_back(blit_pixel(pixel_q.pop_front()));
            end
            if (!(in_valid && !in_ready))
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() > 0 && in_idle_odds > 0
                         && $urandom_range(1, in_idle_odds) == 1)
                begin
                    in_gap = $urandom_range(0, 14);
                    in_valid <= 1'b0;
                end
                else if (pixel_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    red <= pixel_q[0].red;
                    green <= pixel_q[0].green;
                    blue <= pixel_q[0].blue;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (blit_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected result item: offset %h color %h source %h end %b",
                                 dest_offset, packed_color, source_pixel, frame_end);
                    end
                end
                else
                begin
                    want = blit_q.pop_front();
                    if (dest_offset !== want.dest_offset || packed_color !== want.packed_color
                        || source_pixel !== want.source_pixel || frame_end !== want.frame_end)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch: expected offset %h color %h source %h end %b",
                                     want.dest_offset, want.packed_color, want.source_pixel,
                                     want.frame_end);
                            $display("          actual   offset %h color %h source %h end %b",
                                     dest_offset, packed_color, source_pixel, frame_end);
                        end
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap = out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (out_idle_odds > 0 && $urandom_range(1, out_idle_odds) == 1)
            begin
                out_gap = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int random_items;
        int frame_size;
        int n;
        logic [23:0] rgb;
        mode_q = MODE_PORTRAIT_FLIPPED;
        inner_q = COUNT_W'(INNER_COUNT_RESET);
        outer_q = COUNT_W'(OUTER_COUNT_RESET);
        xpitch_q = PITCH_W'(X_PITCH_RESET);
        ypitch_q = PITCH_W'(Y_PITCH_RESET);
        restart_walk();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        in_idle_odds = 4;
        out_idle_odds = 4;
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h07, 8'h03, 8'h07);
        queue_pixel(8'hF8, 8'hFC, 8'hF8);
        wait_idle();

        write_reg(REG_DRAW_MODE, {12'd0, MODE_PORTRAIT_FLIPPED});
        write_reg(REG_INNER_COUNT, 14'd3);
        write_reg(REG_OUTER_COUNT, 14'd2);
        write_reg(REG_X_PITCH, 14'd2);
        write_reg(REG_Y_PITCH, 14'd6);
        end_writes();
        queue_pixel(8'hAA, 8'h55, 8'hAA);
        queue_pixel(8'h55, 8'hAA, 8'h55);
        queue_pixel(8'h80, 8'h40, 8'h20);
        queue_pixel(8'h10, 8'h08, 8'h04);
        queue_pixel(8'h01, 8'h02, 8'h03);
        queue_pixel(8'hFE, 8'hFD, 8'hFC);
        queue_pixel(8'h7F, 8'hBF, 8'hDF);
        wait_idle();

        // The reserved mode acts as landscape with forward source order.
        write_reg(REG_DRAW_MODE, {12'd0, MODE_RESERVED});
        write_reg(REG_INNER_COUNT, 14'd2);
        write_reg(REG_OUTER_COUNT, 14'd2);
        write_reg(REG_X_PITCH, 14'h3FFE);
        write_reg(REG_Y_PITCH, 14'h3FFD);
        end_writes();
        queue_pixel(8'h3C, 8'hC3, 8'h5A);
        queue_pixel(8'hC3, 8'h3C, 8'hA5);
        queue_pixel(8'h0F, 8'hF0, 8'h0F);
        wait_idle();

        // A write to an unused index must leave the frame position alone.
        write_reg(REG_UNUSED, 14'h3FFF);
        end_writes();
        queue_pixel(8'hF0, 8'h0F, 8'hF0);
        queue_pixel(8'h12, 8'h34, 8'h56);
        wait_idle();

        write_reg(REG_INNER_COUNT, 14'd0);
        write_reg(REG_OUTER_COUNT, 14'd0);
        end_writes();
        queue_pixel(8'h9A, 8'hBC, 8'hDE);
        queue_pixel(8'h65, 8'h43, 8'h21);
        wait_idle();

        // Largest frame with pitches chosen so the offset wraps.
        write_reg(REG_DRAW_MODE, {12'd0, MODE_LANDSCAPE});
        write_reg(REG_INNER_COUNT, 14'd2047);
        write_reg(REG_OUTER_COUNT, 14'd1024);
        write_reg(REG_X_PITCH, PITCH_MOST_NEGATIVE);
        write_reg(REG_Y_PITCH, PITCH_MOST_NEGATIVE);
        end_writes();
        queue_pixel(8'hFF, 8'h00, 8'hFF);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        wait_idle();
        write_reg(REG_X_PITCH, PITCH_MOST_POSITIVE);
        write_reg(REG_Y_PITCH, PITCH_MOST_POSITIVE);
        end_writes();
        queue_pixel(8'hC0, 8'h30, 8'h0C);
        queue_pixel(8'h03, 8'hC0, 8'h30);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            if (random_items >= CALM_AFTER)
            begin
                in_idle_odds = 0;
                out_idle_odds = 0;
            end
            else
            begin
                in_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
                out_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
            end
            if ($urandom_range(0, 4) != 0)
            begin
                write_reg(REG_DRAW_MODE, {12'($urandom()), 2'($urandom_range(0, 3))});
                write_reg(REG_INNER_COUNT, pick_count());
                write_reg(REG_OUTER_COUNT, pick_count());
                write_reg(REG_X_PITCH, pick_pitch());
                write_reg(REG_Y_PITCH, pick_pitch());
                if ($urandom_range(0, 9) == 0)
                begin
                    write_reg(3'($urandom_range(5, 7)), 14'($urandom()));
                end
                end_writes();
            end
            frame_size = clamp_dim(inner_q) * clamp_dim(outer_q);
            if (frame_size <= 40)
            begin
                n = frame_size * $urandom_range(1, 3) + $urandom_range(0, frame_size);
            end
            else
            begin
                n = $urandom_range(5, 40);
            end
            repeat (n)
            begin
                rgb = 24'($urandom());
                queue_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
            end
            random_items = random_items + n;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && blit_q.size() == 0)
        begin
            $display("PASS rotated_rgb565_frame_writer");
        end
        else
        begin
            $display("FAIL rotated_rgb565_frame_writer");
        end
        $finish;
    end

endmodule

// ----- rotated_rgb565_frame_writer.f -----
rtl/rrfw_pkg.sv
rtl/rotated_rgb565_frame_writer.sv
sim/tb_rotated_rgb565_frame_writer.sv
